/* rtl/tsrm_pkg.sv */
// Shared types, constants and the sine carrier table of the stereo ring modulator.
// Depends on nothing; every other file of the block imports it.

package tsrm_pkg;

    localparam int TABLE_SIZE   = 512;
    localparam int ADDR_BITS    = $clog2(TABLE_SIZE);
    localparam int SAMPLE_BITS  = 16;
    localparam int PHASE_BITS   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int RATE_BITS    = 16;
    localparam int RATE_SHIFT   = 14;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DATA_BITS = 32;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_STEP = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_MULT = CFG_IDX_BITS'(1);

    localparam logic [PHASE_BITS-1:0] BASE_STEP_RESET = PHASE_BITS'(44739243);
    localparam logic [RATE_BITS-1:0]  RATE_MULT_RESET = RATE_BITS'(16384);

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] SMAX    = 64'((1 << (SAMPLE_BITS - 1)) - 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t                right;
        sample_t                left;
        logic [ADDR_BITS-1:0]   idx;
        logic [FRAC_BITS-1:0]   frac;
    } tsrm_item_t;

    typedef sample_t sine_table_t [TABLE_SIZE];

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int i = 1; i <= 7; i++) begin
            term = (term * x2) >> 30;
            case (i)
                1: begin
                    term = term / 64'd6;
                end
                2: begin
                    term = term / 64'd20;
                end
                3: begin
                    term = term / 64'd42;
                end
                4: begin
                    term = term / 64'd72;
                end
                5: begin
                    term = term / 64'd110;
                end
                6: begin
                    term = term / 64'd156;
                end
                default: begin
                    term = term / 64'd210;
                end
            endcase
            if (i[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        return 64'(sum);
    endfunction

    function automatic sample_t rom_entry(input logic [63:0] k);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] mag;
        q = (64'd4 * k) / TABLE_SIZE;
        r = (64'd4 * k) % TABLE_SIZE;
        if (q[0]) begin
            r = 64'(TABLE_SIZE) - r;
        end
        s   = sin_q30((PI_Q30 * r) / (2 * TABLE_SIZE));
        mag = (s * SMAX + (ONE_Q30 >> 1)) >> 30;
        if (q >= 64'd2) begin
            mag = -mag;
        end
        return mag[SAMPLE_BITS-1:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            t[k] = rom_entry(64'(k));
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

/* rtl/table_sine_ring_modulator.sv */
// Top level of the stereo ring modulator with interpolated table sine carrier.
// Depends on tsrm_pkg, tsrm_front, tsrm_queue and tsrm_back.
//
//   channel   direction  handshake            payload
//   s_        in         s_tvalid/s_tready    left_sample, right_sample
//   m_        out        m_tvalid/m_tready    left_out, right_out
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One stereo pair per cycle while the queue has room and no hold is set.
// The phase add in the front end is the only datapath loop and closes through phase_reg.
// A configuration write blocks input for the following cycle while the step refreshes.
// Reset holds input off through the hold register; the queue absorbs four pairs of output stall.

module table_sine_ring_modulator
    import tsrm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [2*SAMPLE_BITS-1:0] s_tdata,   // left_sample, right_sample
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [2*SAMPLE_BITS-1:0] m_tdata    // left_out, right_out
);

    tsrm_item_t push_item;
    tsrm_item_t pop_item;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    tsrm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    tsrm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    tsrm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/tsrm_front.sv */
// Front end: configuration registers, phase accumulator and item packing.
// Depends on tsrm_pkg; feeds tsrm_queue.

module tsrm_front
    import tsrm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [2*SAMPLE_BITS-1:0] s_tdata,
    input  logic                     q_full,
    output logic                     q_push,
    output tsrm_item_t               q_item
);

    logic [PHASE_BITS-1:0] base_step_reg;
    logic [RATE_BITS-1:0]  rate_mult_reg;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] step_next;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic                  hold_reg;
    logic                  cfg_write;
    logic [PHASE_BITS+RATE_BITS-1:0] step_prod;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign s_tready = !q_full && !hold_reg;
    assign q_push   = s_tvalid && s_tready;

    assign step_prod = base_step_reg * rate_mult_reg
                       + (PHASE_BITS+RATE_BITS)'(1 << (RATE_SHIFT - 1));
    assign step_next = step_prod[RATE_SHIFT +: PHASE_BITS];

    assign phase_next = q_push ? phase_reg + step_reg : phase_reg;

    always_comb begin
        q_item.left  = s_tdata[SAMPLE_BITS-1:0];
        q_item.right = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        q_item.idx   = phase_reg[PHASE_BITS-1 -: ADDR_BITS];
        q_item.frac  = phase_reg[PHASE_BITS-ADDR_BITS-1 -: FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        if (!aresetn) begin
            base_step_reg <= BASE_STEP_RESET;
            rate_mult_reg <= RATE_MULT_RESET;
            phase_reg     <= '0;
            hold_reg      <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            hold_reg  <= cfg_write;
            if (cfg_write) begin
                case (cfg_index)
                    CFG_BASE_STEP: begin
                        base_step_reg <= cfg_data[PHASE_BITS-1:0];
                    end
                    CFG_RATE_MULT: begin
                        rate_mult_reg <= cfg_data[RATE_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/tsrm_queue.sv */
// Short queue between the front end and the back end.
// Depends on tsrm_pkg for the item type and depth.

module tsrm_queue
    import tsrm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  tsrm_item_t push_item,
    input  logic       pop,
    output tsrm_item_t pop_item,
    output logic       full,
    output logic       empty
);

    tsrm_item_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0]  rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0]  count_reg;
    logic [QUEUE_CNT_BITS-1:0]  count_next;
    logic                       do_push;
    logic                       do_pop;

    assign full     = count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

/* rtl/tsrm_back.sv */
// Back end: table read, carrier interpolation and stereo products with saturation.
// Depends on tsrm_pkg for the sine table and item type; pulls from tsrm_queue.

module tsrm_back
    import tsrm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_empty,
    input  tsrm_item_t               q_item,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [2*SAMPLE_BITS-1:0] m_tdata
);

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int IPROD_BITS = DIFF_BITS + FRAC_BITS + 1;
    localparam int MPROD_BITS = 2 * SAMPLE_BITS + 1;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 advance;
    sample_t              a_reg;
    sample_t              b_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    sample_t              l1_reg;
    sample_t              r1_reg;
    sample_t              l2_reg;
    sample_t              r2_reg;
    sample_t              carrier_reg;
    sample_t              carrier_next;
    sample_t              lout_reg;
    sample_t              rout_reg;
    sample_t              lout_next;
    sample_t              rout_next;
    logic [ADDR_BITS-1:0] nxt_idx;

    logic signed [DIFF_BITS-1:0]  diff;
    logic signed [IPROD_BITS-1:0] iprod;
    logic signed [IPROD_BITS-1:0] iround;

    function automatic sample_t modulate(input sample_t s, input sample_t c);
        logic signed [MPROD_BITS-1:0] p;
        logic signed [MPROD_BITS-1:0] q;
        sample_t r;
        p = MPROD_BITS'(s) * MPROD_BITS'(c)
            + MPROD_BITS'(1 << (SAMPLE_BITS - 2));
        q = p >>> (SAMPLE_BITS - 1);
        if (q > $signed(MPROD_BITS'(SMAX))) begin
            r = sample_t'(SMAX);
        end else if (q < -$signed(MPROD_BITS'(SMAX)) - 1) begin
            r = sample_t'(-SMAX - 1);
        end else begin
            r = q[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    assign advance = !v3_reg || m_tready;
    assign q_pop   = advance && !q_empty;
    assign nxt_idx = q_item.idx + 1'b1;

    assign diff   = DIFF_BITS'(b_reg) - DIFF_BITS'(a_reg);
    assign iprod  = IPROD_BITS'(diff) * $signed({1'b0, frac_reg});
    assign iround = (iprod + IPROD_BITS'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign carrier_next = a_reg + iround[SAMPLE_BITS-1:0];

    assign lout_next = modulate(l2_reg, carrier_reg);
    assign rout_next = modulate(r2_reg, carrier_reg);

    assign m_tvalid = v3_reg;
    assign m_tdata  = {rout_reg, lout_reg};

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_reg       <= SINE_TABLE[q_item.idx];
            b_reg       <= SINE_TABLE[nxt_idx];
            frac_reg    <= q_item.frac;
            l1_reg      <= q_item.left;
            r1_reg      <= q_item.right;
            carrier_reg <= carrier_next;
            l2_reg      <= l1_reg;
            r2_reg      <= r1_reg;
            lout_reg    <= lout_next;
            rout_reg    <= rout_next;
        end
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= !q_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

endmodule

/* rtl/tsrm_checker.sv */
// Port-level checks of the ring modulator over time, bound to the top level.
// Depends on tsrm_pkg and table_sine_ring_modulator.

module tsrm_checker
    import tsrm_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     cfg_valid,
    input logic                     cfg_ready,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [2*SAMPLE_BITS-1:0] m_tdata
);

    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 3;

    logic [3:0] inflight_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else if (in_xfer && !out_xfer) begin
            inflight_reg <= inflight_reg + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            inflight_reg <= inflight_reg - 1'b1;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output transaction changed");

    a_no_spurious_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer |-> inflight_reg != '0)
        else $error("output transaction without matching input");

    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 4'(MAX_INFLIGHT))
        else $error("too many transactions in flight");

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("input accepted right after configuration write");

endmodule

bind table_sine_ring_modulator tsrm_checker u_tsrm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

/* tb/tb_table_sine_ring_modulator.sv */
// Self-checking testbench for the stereo ring modulator: directed sample pairs, then
// random pairs under several carrier settings, checked against a local carrier predictor.
// Depends on tsrm_pkg and table_sine_ring_modulator.

module tb_table_sine_ring_modulator;
    import tsrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 129;
    localparam int PHASE_COUNT     = 8;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 6;
    localparam int ROW_COUNT       = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LOW  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HIGH = '1;

    localparam logic [63:0] PI_FIXED   = 64'd3373259426;
    localparam logic [63:0] HALF_FIXED = 64'd536870912;
    localparam longint      PEAK       = 32767;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } pair_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    known;
        sample_t left_exp;
        sample_t right_exp;
    } directed_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [2*SAMPLE_BITS-1:0] s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [2*SAMPLE_BITS-1:0] m_tdata;

    longint          carrier_table [TABLE_SIZE];
    logic [31:0]     phase_acc;
    logic [31:0]     step_base;
    logic [15:0]     step_mult;
    pair_t           modulated_pairs [$];
    int              mismatch_count;
    int              idle_cycles;
    bit              sender_calm;
    bit              receiver_calm;
    bit              hold_request;

    directed_row_t directed_rows [ROW_COUNT] = '{
        '{16'sh7FFF, 16'sh8000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'shFFFF, 16'sh0001, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0001, 16'shFFFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh5555, 16'shAAAA, 1'b0, 16'sh0000, 16'sh0000},
        '{16'shAAAA, 16'sh5555, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh4000, 16'shC000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh7FFF, 16'sh8001, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh00FF, 16'shFF00, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000}
    };

    table_sine_ring_modulator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [63:0] taylor_sine(input logic [63:0] angle);
        logic [63:0] square;
        logic [63:0] term;
        longint      acc;
        square = (angle * angle) >> 30;
        term   = angle;
        acc    = longint'(angle);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * square) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > 64'd1073741824) begin
            acc = 64'd1073741824;
        end
        return 64'(acc);
    endfunction

    function automatic longint sine_entry(input int k);
        logic [63:0] quadrant;
        logic [63:0] offset;
        logic [63:0] level;
        logic [63:0] magnitude;
        quadrant = 64'(4 * k) / 64'(TABLE_SIZE);
        offset   = 64'(4 * k) % 64'(TABLE_SIZE);
        if (quadrant[0]) begin
            offset = 64'(TABLE_SIZE) - offset;
        end
        level     = taylor_sine((PI_FIXED * offset) / 64'(2 * TABLE_SIZE));
        magnitude = (level * 64'(PEAK) + HALF_FIXED) >> 30;
        return (quadrant >= 2) ? -longint'(magnitude) : longint'(magnitude);
    endfunction

    function automatic sample_t scale_sample(input sample_t sample, input longint carrier);
        longint value;
        longint product;
        value   = sample;
        product = (value * carrier + 16384) >>> 15;
        if (product > PEAK) begin
            product = PEAK;
        end
        if (product < -PEAK - 1) begin
            product = -PEAK - 1;
        end
        return sample_t'(product);
    endfunction

    function automatic pair_t modulate_pair(input sample_t left, input sample_t right);
        logic [ADDR_BITS-1:0] lower_idx;
        logic [ADDR_BITS-1:0] upper_idx;
        logic [15:0]          frac;
        longint               frac_value;
        longint               lower;
        longint               upper;
        longint               carrier;
        logic [63:0]          step;
        pair_t                result;
        lower_idx  = phase_acc[31:32-ADDR_BITS];
        upper_idx  = lower_idx + 1'b1;
        frac       = phase_acc[31-ADDR_BITS -: 16];
        frac_value = frac;
        lower      = carrier_table[lower_idx];
        upper      = carrier_table[upper_idx];
        carrier    = lower + (((upper - lower) * frac_value + 32768) >>> 16);
        result.left  = scale_sample(left, carrier);
        result.right = scale_sample(right, carrier);
        step       = (64'(step_base) * 64'(step_mult) + 64'd8192) >> RATE_SHIFT;
        phase_acc  = phase_acc + step[31:0];
        return result;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: begin
                return 16'sh7FFF;
            end
            1: begin
                return 16'sh8000;
            end
            default: begin
                return sample_t'($urandom);
            end
        endcase
    endfunction

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == CFG_BASE_STEP) begin
            step_base = value;
        end else if (index == CFG_RATE_MULT) begin
            step_mult = value[RATE_BITS-1:0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pair(input sample_t left, input sample_t right,
                             input bit known, input pair_t typed);
        int    gap;
        pair_t predicted;
        gap = sender_calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        do @(posedge aclk); while (!s_tready);
        predicted = modulate_pair(left, right);
        modulated_pairs.push_back(known ? typed : predicted);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (modulated_pairs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        pair_t expected;
        pair_t actual;
        if (aresetn && m_tvalid && m_tready) begin
            actual.left  = m_tdata[SAMPLE_BITS-1:0];
            actual.right = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            if (modulated_pairs.size() == 0) begin
                $error("unexpected output transaction left_out=%0d right_out=%0d",
                       actual.left, actual.right);
                mismatch_count++;
            end else begin
                expected = modulated_pairs.pop_front();
                if (actual.left !== expected.left) begin
                    $error("left_out: expected %0d, got %0d", expected.left, actual.left);
                    mismatch_count++;
                end
                if (actual.right !== expected.right) begin
                    $error("right_out: expected %0d, got %0d", expected.right, actual.right);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("table_sine_ring_modulator verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int run;
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end else begin
                run = $urandom_range(1, 24);
                repeat (run) begin
                    @(negedge aclk);
                    m_tready <= 1'b1;
                end
                stall = receiver_calm ? 0 : pick_gap();
                repeat (stall) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    initial begin
        pair_t typed;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        sender_calm    = 1'b0;
        receiver_calm  = 1'b0;
        hold_request   = 1'b0;
        phase_acc      = '0;
        step_base      = BASE_STEP_RESET;
        step_mult      = RATE_MULT_RESET;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            carrier_table[k] = sine_entry(k);
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            typed.left  = directed_rows[i].left_exp;
            typed.right = directed_rows[i].right_exp;
            send_pair(directed_rows[i].left, directed_rows[i].right,
                      directed_rows[i].known, typed);
        end
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            sender_calm   = 1'b0;
            receiver_calm = 1'b0;
            case (p)
                0: begin
                    write_register(CFG_BASE_STEP, BASE_STEP_RESET);
                    write_register(CFG_RATE_MULT, RATE_MULT_RESET);
                    write_register(CFG_UNUSED_LOW, $urandom);
                end
                1: begin
                    write_register(CFG_BASE_STEP, '1);
                    write_register(CFG_RATE_MULT, 32'd32768);
                end
                2: begin
                    write_register(CFG_BASE_STEP, $urandom);
                    write_register(CFG_RATE_MULT, 32'd164);
                    sender_calm   = 1'b1;
                    receiver_calm = 1'b1;
                end
                3: begin
                    write_register(CFG_BASE_STEP, $urandom);
                    write_register(CFG_RATE_MULT, 32'd0);
                end
                4: begin
                    write_register(CFG_BASE_STEP, 32'd0);
                    write_register(CFG_RATE_MULT, 32'd65535);
                    write_register(CFG_UNUSED_HIGH, $urandom);
                end
                5: begin
                    write_register(CFG_BASE_STEP, $urandom);
                    write_register(CFG_RATE_MULT, $urandom_range(164, 32768));
                    sender_calm   = 1'b1;
                    receiver_calm = 1'b1;
                    hold_request  = 1'b1;
                end
                6: begin
                    write_register(CFG_BASE_STEP, $urandom);
                    write_register(CFG_RATE_MULT, 32'd65535);
                end
                default: begin
                    write_register(CFG_RATE_MULT, $urandom_range(0, 65535));
                    write_register(CFG_BASE_STEP, $urandom);
                end
            endcase
            typed = '0;
            repeat (ITEMS_PER_PHASE) begin
                send_pair(pick_sample(), pick_sample(), 1'b0, typed);
            end
            drain_results();
        end

        if (mismatch_count == 0) begin
            $display("table_sine_ring_modulator verification clean");
        end else begin
            $display("table_sine_ring_modulator verification failed");
        end
        $finish;
    end

endmodule
